/* rtl/mtsl_pkg.sv */
// Shared constants, codes and payload types for the sorted-list median block.
package mtsl_pkg;

  // List storage geometry.
  localparam int LIST_DEPTH = 1024;
  localparam int ELEM_WIDTH = 32;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int RES_W      = ELEM_WIDTH + 1;

  // Input mode codes.
  localparam logic [1:0] MODE_PUSH_FIRST  = 2'd0;
  localparam logic [1:0] MODE_PUSH_SECOND = 2'd1;
  localparam logic [1:0] MODE_COMPUTE     = 2'd2;

  // Input item as it arrives on the ports.
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } item_t;

  // Result item as it leaves on the ports.
  typedef struct packed {
    logic signed [RES_W-1:0] median_twice;
    logic                    empty_flag;
    logic                    overflow_flag;
  } result_t;

  // Classified operation handed from the front to the back through the queue.
  typedef struct packed {
    logic                         is_compute;
    logic                         to_second;
    logic signed [ELEM_WIDTH-1:0] elem;
  } op_t;

endpackage

/* rtl/mtsl_front.sv */
// Front stage: accepts input items, decodes the mode and drops unused codes.
module mtsl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  mtsl_pkg::item_t item,
  output logic            op_valid,
  input  logic            op_ready,
  output mtsl_pkg::op_t   op
);
  import mtsl_pkg::*;

  logic st_valid;
  op_t  st_op;
  logic dec_keep;
  op_t  dec_op;

  // The stage takes a new item when empty or when its content moves on.
  assign item_ready = !st_valid || op_ready;
  assign op_valid   = st_valid;
  assign op         = st_op;

  // Mode decode; the unused code produces no operation.
  always_comb begin
    dec_op.elem       = item.value[ELEM_WIDTH-1:0];
    dec_op.is_compute = 1'b0;
    dec_op.to_second  = 1'b0;
    dec_keep          = 1'b1;
    unique case (item.mode)
      MODE_PUSH_FIRST: begin
        dec_op.to_second = 1'b0;
      end
      MODE_PUSH_SECOND: begin
        dec_op.to_second = 1'b1;
      end
      MODE_COMPUTE: begin
        dec_op.is_compute = 1'b1;
      end
      default: begin
        dec_keep = 1'b0;
      end
    endcase
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      st_valid <= dec_keep;
    end else if (op_ready) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      st_op <= dec_op;
    end
  end

endmodule

/* rtl/mtsl_queue.sv */
// Short queue of classified operations between the front and the back.
module mtsl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mtsl_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mtsl_pkg::op_t pop_op
);
  import mtsl_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  op_t               slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QDEPTH[QPTR_W:0]);
  assign pop_valid  = (fill != '0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

/* rtl/mtsl_back.sv */
// Back end: list memories, append handling, merge walk and result register.
module mtsl_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  input  mtsl_pkg::op_t     op,
  output logic              result_valid,
  input  logic              result_ready,
  output mtsl_pkg::result_t result
);
  import mtsl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;

  logic signed [ELEM_WIDTH-1:0] mem_a [LIST_DEPTH];
  logic signed [ELEM_WIDTH-1:0] mem_b [LIST_DEPTH];
  logic signed [ELEM_WIDTH-1:0] rd_a;
  logic signed [ELEM_WIDTH-1:0] rd_b;

  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic             dropped;

  logic [CNT_W-1:0] ptr_a;
  logic [CNT_W-1:0] ptr_b;
  logic [CNT_W-1:0] step;
  logic signed [ELEM_WIDTH-1:0] prev_elem;
  result_t          res;

  logic [CNT_W:0]   total;
  logic [CNT_W-1:0] hi_pos;
  logic             take_a;
  logic signed [ELEM_WIDTH-1:0] pick;
  logic signed [RES_W-1:0]      twice_odd;
  logic signed [RES_W-1:0]      twice_even;
  logic             wr_a;
  logic             wr_b;
  logic             do_op;
  logic             out_free;

  assign op_ready = (state == S_IDLE);
  assign do_op    = op_valid && op_ready;
  assign out_free = !result_valid || result_ready;

  assign total  = {1'b0, count_a} + {1'b0, count_b};
  assign hi_pos = total[CNT_W:1];

  // Appends go to the tail of the chosen list unless it is full.
  assign wr_a = do_op && !op.is_compute && !op.to_second
                && (count_a != LIST_DEPTH[CNT_W-1:0]);
  assign wr_b = do_op && !op.is_compute && op.to_second
                && (count_b != LIST_DEPTH[CNT_W-1:0]);

  // Merge choice: first list wins on a strictly smaller head or an exhausted second list.
  assign take_a = (ptr_a < count_a) && ((ptr_b >= count_b) || (rd_a < rd_b));
  assign pick   = take_a ? rd_a : rd_b;
  assign twice_odd  = {pick, 1'b0};
  assign twice_even = RES_W'($signed({prev_elem[ELEM_WIDTH-1], prev_elem}))
                      + RES_W'($signed({pick[ELEM_WIDTH-1], pick}));

  // List memories with registered reads at the merge pointers.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[count_a[ADDR_W-1:0]] <= op.elem;
    end
    rd_a <= mem_a[ptr_a[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[count_b[ADDR_W-1:0]] <= op.elem;
    end
    rd_b <= mem_b[ptr_b[ADDR_W-1:0]];
  end

  // Control: state, counts, drop flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count_a      <= '0;
      count_b      <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Output valid drops after its transfer unless a new result loads at the same edge.
      if (result_valid && result_ready && (state != S_FIN)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (do_op) begin
            if (op.is_compute) begin
              state <= (total == '0) ? S_FIN : S_READ;
            end else if (wr_a) begin
              count_a <= count_a + 1'b1;
            end else if (wr_b) begin
              count_b <= count_b + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          state <= (step == hi_pos) ? S_FIN : S_READ;
        end
        S_FIN: begin
          if (out_free) begin
            result_valid <= 1'b1;
            count_a      <= '0;
            count_b      <= '0;
            dropped      <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: merge pointers, previous element and the pending result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ptr_a <= '0;
        ptr_b <= '0;
        step  <= '0;
        res.median_twice  <= -RES_W'(2);
        res.empty_flag    <= 1'b1;
        res.overflow_flag <= dropped;
      end
      S_CMP: begin
        prev_elem <= pick;
        step      <= step + 1'b1;
        if (take_a) begin
          ptr_a <= ptr_a + 1'b1;
        end else begin
          ptr_b <= ptr_b + 1'b1;
        end
        if (step == hi_pos) begin
          res.median_twice <= total[0] ? twice_odd : twice_even;
          res.empty_flag   <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      result <= res;
    end
  end

endmodule

/* rtl/median_of_two_sorted_lists.sv */
// Top level of the two-list median block: front stage, operation queue, back end.
// Appends leave the back end idle and ready for the next operation; the front accepts
// one item per cycle until the four-entry queue fills.
// In a compute the merge walk alternates a read state and a compare state for each
// merged element, as the memories have a registered read; a finish state follows.
// Reset clears the counts, drop flag, queue and valid bits; list memories are not
// cleared, since only entries below the counts are ever used.
module median_of_two_sorted_lists (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  mtsl_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output mtsl_pkg::result_t result
);
  import mtsl_pkg::*;

  logic front_valid;
  logic front_ready;
  op_t  front_op;
  logic back_valid;
  logic back_ready;
  op_t  back_op;

  // Input decode stage.
  mtsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .op_valid   (front_valid),
    .op_ready   (front_ready),
    .op         (front_op)
  );

  // Queue that decouples the front from the back end.
  mtsl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_op    (front_op),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_op     (back_op)
  );

  // List storage and merge engine.
  mtsl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (back_valid),
    .op_ready     (back_ready),
    .op           (back_op),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
